// File: sv/rdr_pkg.sv
// Package for the triangle depth rasterizer: parameter defaults, operation codes,
// register indexes and the width of the front-to-back task word.
// No dependencies.
package rdr_pkg;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;
   localparam int DEF_DEPTH_BITS = 16;
   localparam int DEF_COORD_BITS = 12;
   localparam int QUEUE_DEPTH    = 2;

   // Reset values of the screen size registers
   localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd128;
   localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd128;

   // Register indexes (byte address / 4)
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TEST  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Bits of one task word handed from the front to the back
   function automatic int task_bits(input int cb, input int db);
      return 2 + 1 + 14 + 6 * cb + 3 * db + (2 * cb + 3) + 28 + 2;
   endfunction

endpackage

// File: sv/rdr_if.sv
// Channel interfaces of the triangle depth rasterizer: request and response.
// Uses no package.
interface rdr_req_if #(
   parameter int COORD_BITS = 12,
   parameter int DEPTH_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [1:0]                   vertex_index;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic [DEPTH_BITS-1:0]        vertex_depth;
   logic [6:0]                   pixel_x;
   logic [6:0]                   pixel_y;

   modport source (output valid, operation, vertex_index, vertex_x, vertex_y, vertex_depth,
                   pixel_x, pixel_y, input ready);
   modport sink   (input valid, operation, vertex_index, vertex_x, vertex_y, vertex_depth,
                   pixel_x, pixel_y, output ready);
endinterface

interface rdr_rsp_if #(
   parameter int DEPTH_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [6:0]            box_min_x;
   logic [6:0]            box_max_x;
   logic [6:0]            box_min_y;
   logic [6:0]            box_max_y;
   logic                  box_empty;
   logic                  triangle_degenerate;
   logic                  pixel_written;
   logic [6:0]            out_x;
   logic [6:0]            out_y;
   logic [7:0]            intensity;
   logic [DEPTH_BITS-1:0] depth_out;

   modport source (output valid, box_min_x, box_max_x, box_min_y, box_max_y, box_empty,
                   triangle_degenerate, pixel_written, out_x, out_y, intensity, depth_out,
                   input ready);
   modport sink   (input valid, box_min_x, box_max_x, box_min_y, box_max_y, box_empty,
                   triangle_degenerate, pixel_written, out_x, out_y, intensity, depth_out,
                   output ready);
endinterface

// File: sv/triangle_depth_raster.sv
// Triangle depth rasterizer. Holds one triangle of three vertices and a
// MAX_WIDTH x MAX_HEIGHT depth buffer. Every request gives one response. The front
// end takes no new request until it has pushed the task word of the last one. A
// pixel test runs the one-bit-per-cycle depth divider, which is skipped for negative
// or saturated depth and when the pixel misses the triangle or the screen or the
// triangle is degenerate; loads, clears and unused operations skip the datapath.
// After reset the depth buffer is swept to far, one entry per cycle, through all
// MAX_WIDTH * MAX_HEIGHT entries (16384 by default); no request is taken until
// the sweep ends, while register writes are accepted throughout.
// Depends on rdr_pkg, rdr_if, rdr_front, rdr_queue and rdr_back.
module triangle_depth_raster import rdr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   rdr_req_if.sink     req,
   rdr_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = ((XW > YW ? XW : YW) > 8 ? (XW > YW ? XW : YW) : 8) + 1;
   localparam int TW = task_bits(COORD_BITS, DEPTH_BITS);

   logic [7:0]    width_ff, height_ff;
   logic          wr_en;
   logic [CW-1:0] w_ext, h_ext;
   logic [XW-1:0] act_w;
   logic [YW-1:0] act_h;
   logic          busy, q_push, q_pop, q_full, q_empty;
   logic [TW-1:0] q_data, q_head;

   // Register port
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_SCREEN_HEIGHT) ? {24'd0, height_ff} : {24'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
      end else if (wr_en) begin
         if (paddr[2] == REG_SCREEN_WIDTH) width_ff <= pwdata[7:0];
         else                              height_ff <= pwdata[7:0];
      end
   end

   // Active screen size clamped to [1, MAX]
   assign w_ext = CW'(width_ff);
   assign h_ext = CW'(height_ff);
   assign act_w = (w_ext == '0) ? XW'(1) :
                  (w_ext > CW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(w_ext);
   assign act_h = (h_ext == '0) ? YW'(1) :
                  (h_ext > CW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(h_ext);

   rdr_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .DEPTH_BITS(DEPTH_BITS), .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .req(req), .busy(busy),
      .act_w(act_w), .act_h(act_h), .q_full(q_full), .q_push(q_push), .q_data(q_data)
   );

   rdr_queue #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_data),
      .pop(q_pop), .head(q_head), .full(q_full), .empty(q_empty)
   );

   rdr_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .DEPTH_BITS(DEPTH_BITS), .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .q_head(q_head), .q_empty(q_empty),
      .q_pop(q_pop), .busy(busy), .rsp(rsp)
   );

   // No request transfer while the depth buffer is being swept
   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready)
      else $error("request taken during depth sweep");

   // A written pixel is always nearer than far
   a_written_near: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pixel_written |-> rsp.depth_out != '1)
      else $error("written depth equals far");

   // No write means zero gray level and depth
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.pixel_written |-> rsp.intensity == 8'd0 && rsp.depth_out == '0)
      else $error("unwritten result carries depth data");

endmodule

// File: sv/rdr_front.sv
// Front end: takes request transfers, keeps the vertex store, computes the
// triangle area and clamped bounding box, and pushes one task word per item.
// Depends on rdr_pkg and rdr_req_if.
module rdr_front import rdr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   localparam int XW = $clog2(MAX_WIDTH + 1),
   localparam int YW = $clog2(MAX_HEIGHT + 1),
   localparam int TW = task_bits(COORD_BITS, DEPTH_BITS)
) (
   input  logic            clock,
   input  logic            reset,
   rdr_req_if.sink         req,
   input  logic            busy,
   input  logic [XW-1:0]   act_w,
   input  logic [YW-1:0]   act_h,
   input  logic            q_full,
   output logic            q_push,
   output logic [TW-1:0]   q_data
);
   localparam int CB  = COORD_BITS;
   localparam int DB  = DEPTH_BITS;
   localparam int DW  = CB + 1;
   localparam int PW  = 2 * DW;
   localparam int AW  = PW + 1;
   localparam int MW  = (XW > YW) ? XW : YW;
   localparam int BW  = ((CB > MW) ? CB : MW) + 1;
   localparam int SW  = ((MW > 7) ? MW : 7) + 1;

   typedef struct packed {
      logic [1:0]           op;
      logic                 on_screen;
      logic [6:0]           px;
      logic [6:0]           py;
      logic signed [CB-1:0] x0;
      logic signed [CB-1:0] y0;
      logic signed [CB-1:0] x1;
      logic signed [CB-1:0] y1;
      logic signed [CB-1:0] x2;
      logic signed [CB-1:0] y2;
      logic [DB-1:0]        d0;
      logic [DB-1:0]        d1;
      logic [DB-1:0]        d2;
      logic signed [AW-1:0] area;
      logic [6:0]           bx0;
      logic [6:0]           bx1;
      logic [6:0]           by0;
      logic [6:0]           by1;
      logic                 empty;
      logic                 degen;
   } task_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_PROD = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type           st_ff, st_in;
   logic [1:0]           op_ff;
   logic                 onscr_ff;
   logic [6:0]           px_ff, py_ff;
   logic signed [CB-1:0] vx_ff [3];
   logic signed [CB-1:0] vy_ff [3];
   logic [DB-1:0]        vd_ff [3];
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic                 accept;
   logic signed [DW-1:0] dx10, dy20, dy10, dx20;
   logic signed [AW-1:0] area;
   logic signed [CB-1:0] minx, maxx, miny, maxy;
   logic signed [BW-1:0] wm1, hm1, bx0, bx1, by0, by1, ox0, ox1, oy0, oy1;
   task_type             tk;

   assign req.ready = (st_ff == F_IDLE) && !busy;
   assign accept    = req.valid && req.ready;

   // Sequencer: accept, area products, push
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         F_IDLE: if (accept) st_in = F_PROD;
         F_PROD: st_in = F_PUSH;
         F_PUSH: if (!q_full) st_in = F_IDLE;
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vd_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (accept && req.operation == OP_LOAD && req.vertex_index != 2'd3) begin
            vx_ff[req.vertex_index] <= req.vertex_x;
            vy_ff[req.vertex_index] <= req.vertex_y;
            vd_ff[req.vertex_index] <= req.vertex_depth;
         end
      end
   end

   // Item fields
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req.operation;
         px_ff    <= req.pixel_x;
         py_ff    <= req.pixel_y;
         onscr_ff <= (SW'(req.pixel_x) < SW'(act_w)) && (SW'(req.pixel_y) < SW'(act_h));
      end
   end

   // Area products of the stored triangle
   assign dx10 = DW'(vx_ff[1]) - DW'(vx_ff[0]);
   assign dy20 = DW'(vy_ff[2]) - DW'(vy_ff[0]);
   assign dy10 = DW'(vy_ff[1]) - DW'(vy_ff[0]);
   assign dx20 = DW'(vx_ff[2]) - DW'(vx_ff[0]);

   always_ff @(posedge clock) begin
      if (st_ff == F_PROD) begin
         pa_ff <= PW'(dx10) * PW'(dy20);
         pb_ff <= PW'(dy10) * PW'(dx20);
      end
   end

   assign area = AW'(pa_ff) - AW'(pb_ff);

   // Bounding box clamped to the active screen
   always_comb begin
      minx = vx_ff[0];
      maxx = vx_ff[0];
      miny = vy_ff[0];
      maxy = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < minx) minx = vx_ff[i];
         if (vx_ff[i] > maxx) maxx = vx_ff[i];
         if (vy_ff[i] < miny) miny = vy_ff[i];
         if (vy_ff[i] > maxy) maxy = vy_ff[i];
      end
   end

   assign wm1 = signed'(BW'(act_w)) - signed'(BW'(1));
   assign hm1 = signed'(BW'(act_h)) - signed'(BW'(1));
   assign bx0 = (minx < 0) ? '0 : BW'(minx);
   assign bx1 = (BW'(maxx) > wm1) ? wm1 : BW'(maxx);
   assign by0 = (miny < 0) ? '0 : BW'(miny);
   assign by1 = (BW'(maxy) > hm1) ? hm1 : BW'(maxy);
   assign ox0 = (bx0 > wm1) ? wm1 : bx0;
   assign ox1 = (bx1 < 0) ? '0 : bx1;
   assign oy0 = (by0 > hm1) ? hm1 : by0;
   assign oy1 = (by1 < 0) ? '0 : by1;

   // Task word
   always_comb begin
      tk.op        = op_ff;
      tk.on_screen = onscr_ff;
      tk.px        = px_ff;
      tk.py        = py_ff;
      tk.x0        = vx_ff[0];
      tk.y0        = vy_ff[0];
      tk.x1        = vx_ff[1];
      tk.y1        = vy_ff[1];
      tk.x2        = vx_ff[2];
      tk.y2        = vy_ff[2];
      tk.d0        = vd_ff[0];
      tk.d1        = vd_ff[1];
      tk.d2        = vd_ff[2];
      tk.area      = area;
      tk.bx0       = ox0[6:0];
      tk.bx1       = ox1[6:0];
      tk.by0       = oy0[6:0];
      tk.by1       = oy1[6:0];
      tk.empty     = (bx0 > bx1) || (by0 > by1);
      tk.degen     = (area == '0);
   end

   assign q_push = (st_ff == F_PUSH) && !q_full;
   assign q_data = tk;

endmodule

// File: sv/rdr_queue.sv
// Small FIFO that decouples the front end from the back end.
// Depends on rdr_pkg.
module rdr_queue import rdr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTW-1:0]   wr_ff, rd_ff;
   logic [CNW-1:0]   cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PTW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == PTW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// File: sv/rdr_back.sv
// Back end: owns the depth buffer, runs the edge test, depth interpolation
// with a bit-serial divider, the depth compare and write, and the result register.
// Depends on rdr_pkg and rdr_rsp_if.
module rdr_back import rdr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   localparam int TW = task_bits(COORD_BITS, DEPTH_BITS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [TW-1:0] q_head,
   input  logic          q_empty,
   output logic          q_pop,
   output logic          busy,
   rdr_rsp_if.source     rsp
);
   localparam int CB   = COORD_BITS;
   localparam int DB   = DEPTH_BITS;
   localparam int DW   = CB + 1;
   localparam int PW   = 2 * DW;
   localparam int AW   = PW + 1;
   localparam int EW   = PW + 1;
   localparam int NPW  = EW + DB + 1;
   localparam int NW   = NPW + 2;
   localparam int ENT  = MAX_WIDTH * MAX_HEIGHT;
   localparam int IW   = $clog2(ENT);
   localparam int CNTW = $clog2(DB);
   localparam logic [DB-1:0] FAR = '1;

   typedef struct packed {
      logic [1:0]           op;
      logic                 on_screen;
      logic [6:0]           px;
      logic [6:0]           py;
      logic signed [CB-1:0] x0;
      logic signed [CB-1:0] y0;
      logic signed [CB-1:0] x1;
      logic signed [CB-1:0] y1;
      logic signed [CB-1:0] x2;
      logic signed [CB-1:0] y2;
      logic [DB-1:0]        d0;
      logic [DB-1:0]        d1;
      logic [DB-1:0]        d2;
      logic signed [AW-1:0] area;
      logic [6:0]           bx0;
      logic [6:0]           bx1;
      logic [6:0]           by0;
      logic [6:0]           by1;
      logic                 empty;
      logic                 degen;
   } task_type;

   typedef enum logic [9:0] {
      B_CLEAR = 10'b0000000001,
      B_IDLE  = 10'b0000000010,
      B_PROD  = 10'b0000000100,
      B_EDGE  = 10'b0000001000,
      B_NUMP  = 10'b0000010000,
      B_NUM   = 10'b0000100000,
      B_CHK   = 10'b0001000000,
      B_DIV   = 10'b0010000000,
      B_CMP   = 10'b0100000000,
      B_DONE  = 10'b1000000000
   } bstate_type;

   bstate_type            st_ff, st_in;
   task_type              hd, tk_ff;
   logic [IW-1:0]         clr_ff, idx_ff;
   logic [DB-1:0]         mem [ENT];
   logic [DB-1:0]         rd_ff;
   logic                  we;
   logic [IW-1:0]         wa;
   logic [DB-1:0]         wd;
   logic signed [PW-1:0]  m_ff [6];
   logic signed [EW-1:0]  w0_ff, w1_ff, w2_ff;
   logic signed [EW-1:0]  w0, w1, w2;
   logic signed [NPW-1:0] n_ff [3];
   logic signed [NW-1:0]  num_ff;
   logic [NW-1:0]         den_ff, rem_ff, dsh_ff;
   logic [DB-1:0]         q_ff, z_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic                  wr_ff;
   logic                  ov_ff;
   logic                  in_tri, out_free;
   logic signed [NW-1:0]  num_sum;
   logic [NW-1:0]         num_u, limit;
   logic                  div_ge;
   logic [DB:0]           inv;
   logic [DB+8:0]         inten_w;
   logic signed [DW-1:0]  pxs, pys;

   assign hd       = q_head;
   assign busy     = (st_ff == B_CLEAR);
   assign out_free = !ov_ff || rsp.ready;
   assign q_pop    = (st_ff == B_IDLE) && !q_empty;

   // Edge functions from the registered products
   assign w0     = EW'(m_ff[0]) - EW'(m_ff[1]);
   assign w1     = EW'(m_ff[2]) - EW'(m_ff[3]);
   assign w2     = EW'(m_ff[4]) - EW'(m_ff[5]);
   assign in_tri = (w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0);

   assign num_sum = NW'(n_ff[0]) + NW'(n_ff[1]) + NW'(n_ff[2]);
   assign num_u   = NW'(num_ff);
   assign limit   = den_ff << DB;
   assign div_ge  = (rem_ff >= dsh_ff);

   // Sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         B_CLEAR: if (clr_ff == IW'(ENT - 1)) st_in = B_IDLE;
         B_IDLE:  if (!q_empty) st_in = (hd.op == OP_TEST) ? B_PROD : B_DONE;
         B_PROD:  st_in = B_EDGE;
         B_EDGE:  st_in = (tk_ff.on_screen && !tk_ff.degen && in_tri) ? B_NUMP : B_DONE;
         B_NUMP:  st_in = B_NUM;
         B_NUM:   st_in = B_CHK;
         B_CHK:   st_in = (num_ff < 0 || num_u >= limit) ? B_CMP : B_DIV;
         B_DIV:   if (cnt_ff == '0) st_in = B_CMP;
         B_CMP:   st_in = B_DONE;
         B_DONE:  if (out_free) st_in = B_IDLE;
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_CLEAR;
         clr_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   // Depth buffer write port: clearing sweep, clear op, passing test
   always_comb begin
      we = 1'b0;
      wa = idx_ff;
      wd = FAR;
      case (st_ff)
         B_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
         end
         B_IDLE: begin
            wa = IW'(IW'(hd.py) * IW'(MAX_WIDTH) + IW'(hd.px));
            we = !q_empty && hd.op == OP_CLEAR && hd.on_screen;
         end
         B_CMP: begin
            we = (z_ff < rd_ff);
            wd = z_ff;
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[idx_ff];
   end

   // Datapath
   assign pxs = signed'(DW'(tk_ff.px));
   assign pys = signed'(DW'(tk_ff.py));

   always_ff @(posedge clock) begin
      case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               tk_ff  <= hd;
               idx_ff <= IW'(IW'(hd.py) * IW'(MAX_WIDTH) + IW'(hd.px));
               wr_ff  <= 1'b0;
               z_ff   <= '0;
            end
         end
         B_PROD: begin
            m_ff[0] <= PW'(DW'(tk_ff.x1) - DW'(tk_ff.x0)) * PW'(pys - DW'(tk_ff.y0));
            m_ff[1] <= PW'(DW'(tk_ff.y1) - DW'(tk_ff.y0)) * PW'(pxs - DW'(tk_ff.x0));
            m_ff[2] <= PW'(DW'(tk_ff.x2) - DW'(tk_ff.x1)) * PW'(pys - DW'(tk_ff.y1));
            m_ff[3] <= PW'(DW'(tk_ff.y2) - DW'(tk_ff.y1)) * PW'(pxs - DW'(tk_ff.x1));
            m_ff[4] <= PW'(DW'(tk_ff.x0) - DW'(tk_ff.x2)) * PW'(pys - DW'(tk_ff.y2));
            m_ff[5] <= PW'(DW'(tk_ff.y0) - DW'(tk_ff.y2)) * PW'(pxs - DW'(tk_ff.x2));
         end
         B_EDGE: begin
            w0_ff <= w0;
            w1_ff <= w1;
            w2_ff <= w2;
         end
         B_NUMP: begin
            // weight opposite each vertex times its depth
            n_ff[0] <= NPW'(w1_ff) * signed'(NPW'(tk_ff.d0));
            n_ff[1] <= NPW'(w2_ff) * signed'(NPW'(tk_ff.d1));
            n_ff[2] <= NPW'(w0_ff) * signed'(NPW'(tk_ff.d2));
         end
         B_NUM: begin
            // normalize so the area is positive
            if (tk_ff.area < 0) begin
               num_ff <= -num_sum;
               den_ff <= NW'(-NW'(tk_ff.area));
            end else begin
               num_ff <= num_sum;
               den_ff <= NW'(tk_ff.area);
            end
         end
         B_CHK: begin
            rem_ff <= num_u;
            dsh_ff <= den_ff << (DB - 1);
            cnt_ff <= CNTW'(DB - 1);
            q_ff   <= '0;
            if (num_ff < 0)          z_ff <= '0;
            else if (num_u >= limit) z_ff <= FAR;
         end
         B_DIV: begin
            // one quotient bit per cycle
            if (div_ge) rem_ff <= rem_ff - dsh_ff;
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= {q_ff[DB-2:0], div_ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) z_ff <= {q_ff[DB-2:0], div_ge};
         end
         B_CMP: begin
            wr_ff <= (z_ff < rd_ff);
         end
         default: ;
      endcase
   end

   // Gray level: floor((2^DB - z) * 255 / 2^DB)
   assign inv     = {1'b1, {DB{1'b0}}} - {1'b0, z_ff};
   assign inten_w = {inv, 8'b0} - (DB + 9)'(inv);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (st_ff == B_DONE && out_free) begin
         ov_ff <= 1'b1;
      end else if (rsp.ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_DONE && out_free) begin
         rsp.box_min_x           <= tk_ff.bx0;
         rsp.box_max_x           <= tk_ff.bx1;
         rsp.box_min_y           <= tk_ff.by0;
         rsp.box_max_y           <= tk_ff.by1;
         rsp.box_empty           <= tk_ff.empty;
         rsp.triangle_degenerate <= tk_ff.degen;
         rsp.pixel_written       <= wr_ff;
         rsp.intensity           <= wr_ff ? inten_w[DB+7:DB] : 8'd0;
         rsp.depth_out           <= wr_ff ? z_ff : '0;
         if (tk_ff.op == OP_TEST || tk_ff.op == OP_CLEAR) begin
            rsp.out_x <= tk_ff.px;
            rsp.out_y <= tk_ff.py;
         end else begin
            rsp.out_x <= 7'd0;
            rsp.out_y <= 7'd0;
         end
      end
   end

   assign rsp.valid = ov_ff;

endmodule

// File: verif/triangle_depth_raster_test.sv
// Self-checking testbench for triangle_depth_raster: loads, pixel tests and clears,
// checked transfer by transfer against an internal rasterizer and depth-buffer model.
// Depends on rdr_pkg, rdr_if and triangle_depth_raster.
`timescale 1ns / 100ps

module triangle_depth_raster_test import rdr_pkg::*; ();

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam logic [1:0] VERTEX_NONE   = 2'd3;
   localparam int         SCREEN_MAX    = 128;
   localparam int         DEPTH_FAR     = 65535;
   localparam int         STALL_LIMIT   = 100000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         DRAIN_CYCLES  = 40;

   typedef struct {
      logic [1:0]         op;
      logic [1:0]         vi;
      logic signed [11:0] vx;
      logic signed [11:0] vy;
      logic [15:0]        vd;
      logic [6:0]         px;
      logic [6:0]         py;
   } raster_req_type;

   typedef struct {
      logic [6:0]  min_x;
      logic [6:0]  max_x;
      logic [6:0]  min_y;
      logic [6:0]  max_y;
      logic        empty;
      logic        degen;
      logic        written;
      logic [6:0]  ox;
      logic [6:0]  oy;
      logic [7:0]  inten;
      logic [15:0] depth;
   } raster_rsp_type;

   // Triangle, depth buffer and screen size model; holds the results still owed
   class raster_scoreboard;
      longint         vert_x[3];
      longint         vert_y[3];
      longint         vert_d[3];
      longint         area;
      int             zbuf[SCREEN_MAX * SCREEN_MAX];
      int             width_reg;
      int             height_reg;
      raster_rsp_type owed_q[$];
      int             errors;

      function new();
         for (int i = 0; i < 3; i++) begin
            vert_x[i] = 0;
            vert_y[i] = 0;
            vert_d[i] = 0;
         end
         area = 0;
         foreach (zbuf[i]) zbuf[i] = DEPTH_FAR;
         width_reg  = RST_SCREEN_WIDTH;
         height_reg = RST_SCREEN_HEIGHT;
         errors = 0;
      endfunction

      function void write_reg(logic idx, int value);
         if (idx == REG_SCREEN_WIDTH) width_reg = value & 8'hFF;
         else height_reg = value & 8'hFF;
      endfunction

      function longint edge_fn(int a, int b, longint x, longint y);
         return (vert_x[b] - vert_x[a]) * (y - vert_y[a])
              - (vert_y[b] - vert_y[a]) * (x - vert_x[a]);
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void note_request(raster_req_type r);
         raster_rsp_type e;
         longint w, h, x, y, w0, w1, w2, num, a, z, bx0, bx1, by0, by1;
         int idx;
         w = clip(width_reg, 1, SCREEN_MAX);
         h = clip(height_reg, 1, SCREEN_MAX);
         x = r.px;
         y = r.py;
         e.written = 0;
         e.ox = 0;
         e.oy = 0;
         e.inten = 0;
         e.depth = 0;
         idx = int'(y) * SCREEN_MAX + int'(x);
         if (r.op == OP_LOAD) begin
            if (r.vi != VERTEX_NONE) begin
               vert_x[r.vi] = r.vx;
               vert_y[r.vi] = r.vy;
               vert_d[r.vi] = r.vd;
               area = edge_fn(0, 1, vert_x[2], vert_y[2]);
            end
         end else if (r.op == OP_TEST) begin
            e.ox = r.px;
            e.oy = r.py;
            if (x < w && y < h && area != 0) begin
               w0 = edge_fn(0, 1, x, y);
               w1 = edge_fn(1, 2, x, y);
               w2 = edge_fn(2, 0, x, y);
               if ((w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0)) begin
                  // each weight is the edge opposite its vertex
                  num = w1 * vert_d[0] + w2 * vert_d[1] + w0 * vert_d[2];
                  a = area;
                  if (a < 0) begin
                     a = -a;
                     num = -num;
                  end
                  z = (num < 0) ? 0 : clip(num / a, 0, DEPTH_FAR);
                  if (z < zbuf[idx]) begin
                     zbuf[idx] = int'(z);
                     e.written = 1;
                     e.depth = z[15:0];
                     e.inten = 8'(((65536 - z) * 255) >>> 16);
                  end
               end
            end
         end else if (r.op == OP_CLEAR) begin
            e.ox = r.px;
            e.oy = r.py;
            if (x < w && y < h) zbuf[idx] = DEPTH_FAR;
         end
         // box of the triangle as stored after this request
         bx0 = vert_x[0] < vert_x[1] ? vert_x[0] : vert_x[1];
         bx0 = bx0 < vert_x[2] ? bx0 : vert_x[2];
         bx1 = vert_x[0] > vert_x[1] ? vert_x[0] : vert_x[1];
         bx1 = bx1 > vert_x[2] ? bx1 : vert_x[2];
         by0 = vert_y[0] < vert_y[1] ? vert_y[0] : vert_y[1];
         by0 = by0 < vert_y[2] ? by0 : vert_y[2];
         by1 = vert_y[0] > vert_y[1] ? vert_y[0] : vert_y[1];
         by1 = by1 > vert_y[2] ? by1 : vert_y[2];
         if (bx0 < 0) bx0 = 0;
         if (bx1 > w - 1) bx1 = w - 1;
         if (by0 < 0) by0 = 0;
         if (by1 > h - 1) by1 = h - 1;
         e.empty = (bx0 > bx1 || by0 > by1);
         e.min_x = 7'(clip(bx0, 0, w - 1));
         e.max_x = 7'(clip(bx1, 0, w - 1));
         e.min_y = 7'(clip(by0, 0, h - 1));
         e.max_y = 7'(clip(by1, 0, h - 1));
         e.degen = (area == 0);
         owed_q.push_back(e);
      endfunction

      function void compare(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(raster_rsp_type a);
         raster_rsp_type e;
         if (owed_q.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         e = owed_q.pop_front();
         compare("box_min_x", e.min_x, a.min_x);
         compare("box_max_x", e.max_x, a.max_x);
         compare("box_min_y", e.min_y, a.min_y);
         compare("box_max_y", e.max_y, a.max_y);
         compare("box_empty", e.empty, a.empty);
         compare("triangle_degenerate", e.degen, a.degen);
         compare("pixel_written", e.written, a.written);
         compare("out_x", e.ox, a.ox);
         compare("out_y", e.oy, a.oy);
         compare("intensity", e.inten, a.inten);
         compare("depth_out", e.depth, a.depth);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rdr_req_if req_if ();
   rdr_rsp_if rsp_if ();

   triangle_depth_raster u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if.sink),
      .rsp     (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   raster_scoreboard sb;
   int send_idle;
   int recv_idle;
   bit hold_request;
   int quiet_cycles;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin : recv_ctl
      int hold_left;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Response check and watchdog; sampled mid-cycle, ahead of the edge that transfers
   always @(negedge clock) begin
      raster_rsp_type a;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            a.min_x   = rsp_if.box_min_x;
            a.max_x   = rsp_if.box_max_x;
            a.min_y   = rsp_if.box_min_y;
            a.max_y   = rsp_if.box_max_y;
            a.empty   = rsp_if.box_empty;
            a.degen   = rsp_if.triangle_degenerate;
            a.written = rsp_if.pixel_written;
            a.ox      = rsp_if.out_x;
            a.oy      = rsp_if.out_y;
            a.inten   = rsp_if.intensity;
            a.depth   = rsp_if.depth_out;
            sb.check_response(a);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("triangle_depth_raster regression: fail");
            $finish;
         end
      end
   end

   function automatic raster_req_type make_req(logic [1:0] op, logic [1:0] vi, int x, int y,
                                               int d, int px, int py);
      raster_req_type r;
      r.op = op;
      r.vi = vi;
      r.vx = 12'(x);
      r.vy = 12'(y);
      r.vd = 16'(d);
      r.px = 7'(px);
      r.py = 7'(py);
      return r;
   endfunction

   // One request transfer; called and returns at a rising edge
   task automatic send_request(raster_req_type r);
      while ($urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.operation    <= r.op;
      req_if.vertex_index <= r.vi;
      req_if.vertex_x     <= r.vx;
      req_if.vertex_y     <= r.vy;
      req_if.vertex_depth <= r.vd;
      req_if.pixel_x      <= r.px;
      req_if.pixel_y      <= r.py;
      forever begin
         @(negedge clock);
         if (req_if.ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic csr_write(logic idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random triangles with pixel tests and clears over the screen and just past it, mixed with raw noise requests
   task automatic random_traffic(int count);
      int sent, w, h, k, px, py, dbase;
      raster_req_type r;
      sent = 0;
      w = (sb.width_reg < 1) ? 1 : (sb.width_reg > SCREEN_MAX ? SCREEN_MAX : sb.width_reg);
      h = (sb.height_reg < 1) ? 1 : (sb.height_reg > SCREEN_MAX ? SCREEN_MAX : sb.height_reg);
      while (sent < count) begin
         if ($urandom_range(0, 99) < 12) begin
            r = make_req(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            send_request(r);
            if (r.op != OP_UNUSED) sent++;
         end else begin
            dbase = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
            for (int v = 0; v < 3; v++) begin
               send_request(make_req(OP_LOAD, 2'(v),
                  int'($urandom_range(0, w + 31)) - 16,
                  int'($urandom_range(0, h + 31)) - 16,
                  (dbase != 0) ? dbase : $urandom, $urandom, $urandom));
               sent++;
            end
            k = $urandom_range(3, 14);
            for (int i = 0; i < k; i++) begin
               px = $urandom_range(0, (w + 3 > 127) ? 127 : w + 3);
               py = $urandom_range(0, (h + 3 > 127) ? 127 : h + 3);
               if ($urandom_range(0, 99) < 15)
                  send_request(make_req(OP_CLEAR, 2'($urandom), $urandom, $urandom,
                                        $urandom, px, py));
               else
                  send_request(make_req(OP_TEST, 2'($urandom), $urandom, $urandom,
                                        $urandom, px, py));
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(int w, int h, int s_idle, int r_idle, int count, bit hold);
      drain();
      csr_write(REG_SCREEN_WIDTH, w);
      csr_write(REG_SCREEN_HEIGHT, h);
      send_idle = s_idle;
      recv_idle = r_idle;
      if (hold) hold_request = 1'b1;
      random_traffic(count);
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.operation = OP_LOAD;
      req_if.vertex_index = '0;
      req_if.vertex_x = '0;
      req_if.vertex_y = '0;
      req_if.vertex_depth = '0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      send_idle = 0;
      recv_idle = 0;
      hold_request = 1'b0;
      quiet_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coordinate and depth extremes, collinear triangle, bad slot, unused op
      send_request(make_req(OP_LOAD, 2'd0, -2048, -2048, 0, 0, 0));
      send_request(make_req(OP_LOAD, 2'd1, 2047, 2047, 65535, 0, 0));
      send_request(make_req(OP_LOAD, VERTEX_NONE, 5, 5, 5, 0, 0));
      send_request(make_req(OP_UNUSED, 2'd0, 0, 0, 0, 127, 127));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 10, 10));
      send_request(make_req(OP_LOAD, 2'd2, 2047, -2048, 32768, 0, 0));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 127, 0));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 0, 0));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 64, 10));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 64, 10));
      send_request(make_req(OP_CLEAR, 2'd0, 0, 0, 0, 64, 10));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 64, 10));
      send_request(make_req(OP_CLEAR, 2'd0, 0, 0, 0, 127, 127));
      // small triangle, same winding as the last; vertex, edge and outside points
      send_request(make_req(OP_LOAD, 2'd0, 10, 10, 0, 0, 0));
      send_request(make_req(OP_LOAD, 2'd1, 10, 50, 65535, 0, 0));
      send_request(make_req(OP_LOAD, 2'd2, 50, 10, 100, 0, 0));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 10, 10));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 30, 30));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 60, 60));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 11, 11));
      send_request(make_req(OP_TEST, 2'd0, 0, 0, 0, 10, 50));

      // Random phases across screen sizes and idling patterns
      run_phase(128, 128, 0, 0, 300, 1'b0);
      run_phase(1, 1, 78, 0, 150, 1'b0);
      run_phase(0, 255, 0, 78, 150, 1'b0);
      run_phase(64, 100, 27, 27, 300, 1'b1);
      run_phase(128, 1, 0, 0, 150, 1'b0);
      run_phase(255, 0, 78, 0, 100, 1'b0);
      run_phase(37, 128, 0, 0, 350, 1'b1);

      drain();
      if (sb.errors == 0)
         $display("triangle_depth_raster regression: pass");
      else
         $display("triangle_depth_raster regression: fail");
      $finish;
   end

endmodule
